@@ rtl/interval_block_merge_unit_macros.svh @@
// Assertion macros shared by the interval block merge RTL.
// Depends on nothing; included by modules that carry assertions.
`ifndef INTERVAL_BLOCK_MERGE_UNIT_MACROS_SVH
`define INTERVAL_BLOCK_MERGE_UNIT_MACROS_SVH

// same-cycle implication
`define IBM_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define IBM_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/ibm_pkg.sv @@
// Types and constants of the interval block merge unit.
// No dependencies.
`default_nettype none
package ibm_pkg;
   localparam int TABLE_DEPTH = 32;
   localparam int COORD_BITS  = 16;
   localparam int IDX_BITS    = $clog2(TABLE_DEPTH);
   localparam int CNT_BITS    = $clog2(TABLE_DEPTH + 1);
   localparam logic [COORD_BITS-1:0] COORD_MAX = '1;

   localparam logic [1:0] OP_MATCH    = 2'd0;
   localparam logic [1:0] OP_MISMATCH = 2'd1;
   localparam logic [1:0] OP_DELETION = 2'd2;
   localparam logic [1:0] OP_INSERT   = 2'd3;

   localparam logic FUNC_ELEMENT = 1'b0;
   localparam logic FUNC_CLEAR   = 1'b1;
   localparam logic KIND_REMAP   = 1'b0;
   localparam logic KIND_NEW     = 1'b1;

   localparam logic [2:0] ADDR_MIN_OVERLAP = 3'd0;

   typedef struct packed {
      logic        func;
      logic [1:0]  op_kind;
      logic        trim;
      logic [15:0] run_length;
      logic        no_elements;
      logic        last;
   } req_type;

   typedef struct packed {
      logic        kind;
      logic [4:0]  old_index;
      logic [4:0]  dest_index;
      logic        absorbed;
      logic [15:0] block_start;
      logic [15:0] block_end;
      logic [15:0] clip_len;
      logic        overflow;
      logic        done_res;
   } rsp_type;

   typedef struct packed {
      logic [COORD_BITS-1:0] lo;
      logic [COORD_BITS-1:0] hi;
      logic [COORD_BITS-1:0] clip;
   } entry_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_PLACE,
      ST_EMIT,
      ST_FINAL
   } state_type;

   function automatic logic [COORD_BITS-1:0] sat_add(input logic [COORD_BITS-1:0] a,
                                                     input logic [COORD_BITS-1:0] b);
      logic [COORD_BITS:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[COORD_BITS] ? COORD_MAX : s[COORD_BITS-1:0];
   endfunction
endpackage
`default_nettype wire

@@ rtl/interval_block_merge_unit.sv @@
// Interval block merge unit: span accumulation and sorted block table merge.
// Depends on ibm_pkg and interval_block_merge_unit_macros.svh.
//
//   channel   ports                 direction  contents
//   request   req_valid/ready/data  in         one alignment element or clear
//   response  rsp_valid/ready/data  out        remap per old block, then new block
//   config    psel..prdata (APB)    in         min_overlap at byte address 0
//
// A non-last element or a clear is taken in ST_IDLE; config writes are always ready.
// A merge walks the n stored blocks in three passes (scan, place up to the
// insertion point, emit) and then gives the new block.
// Response stalls hold the walk; the table lives in two ping-pong banks.
// Reset (synchronous, active high) empties the table and clears the span.
`default_nettype none
`include "interval_block_merge_unit_macros.svh"
module interval_block_merge_unit
   import ibm_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data,
   input  wire logic    psel,
   input  wire logic    penable,
   input  wire logic    pwrite,
   input  wire logic [2:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]  prdata,
   output logic         pready
);
   state_type state_ff, state_in;
   logic [COORD_BITS-1:0] mo_ff;
   logic [COORD_BITS-1:0] ss_ff, ss_in, se_ff, se_in, rt_ff, rt_in;
   logic seen_ff, seen_in;
   logic [COORD_BITS-1:0] lo_ff, lo_in, hi_ff, hi_in, bound_ff, bound_in, clip_ff, clip_in;
   logic any_ff, any_in, ovf_ff, ovf_in, bank_ff, bank_in;
   logic [CNT_BITS-1:0] idx_ff, idx_in, cnt_ff, cnt_in, j_ff, j_in, brk_ff, brk_in, c_ff, c_in;
   logic [TABLE_DEPTH-1:0] mark_ff, mark_in;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;
   entry_type tab_a [TABLE_DEPTH];
   entry_type tab_b [TABLE_DEPTH];
   entry_type rd_ff, wr_data;
   logic wr_en;
   logic [IDX_BITS-1:0] wr_addr, ri, rd_addr;
   logic out_free, apart, at_end;
   logic [CNT_BITS-1:0] d;

   assign pready    = 1'b1;
   assign prdata    = (paddr[2] == ADDR_MIN_OVERLAP[2]) ? {16'd0, mo_ff} : 32'd0;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   assign ri = idx_ff[IDX_BITS-1:0];
   // read port is fetched with the next walk index, so rd_ff holds entry idx_ff
   assign rd_addr = idx_in[IDX_BITS-1:0];
   assign at_end = (idx_ff == cnt_ff);
   assign apart = (lo_ff >= rd_ff.hi || (rd_ff.hi - lo_ff) < mo_ff) ||
                  (hi_ff <= rd_ff.lo || (hi_ff - rd_ff.lo) < mo_ff);
   assign d = ovf_ff ? idx_ff : c_ff + ((idx_ff >= brk_ff) ? CNT_BITS'(1) : CNT_BITS'(0));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         mo_ff <= '0;
         ss_ff <= '0; se_ff <= '0; rt_ff <= '0;
         seen_ff <= 1'b0;
         cnt_ff <= '0;
         bank_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (psel && penable && pwrite && paddr[2] == ADDR_MIN_OVERLAP[2])
            mo_ff <= pwdata[COORD_BITS-1:0];
         ss_ff <= ss_in; se_ff <= se_in; rt_ff <= rt_in;
         seen_ff <= seen_in;
         cnt_ff <= cnt_in;
         bank_ff <= bank_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      lo_ff <= lo_in; hi_ff <= hi_in; bound_ff <= bound_in; clip_ff <= clip_in;
      any_ff <= any_in; ovf_ff <= ovf_in;
      idx_ff <= idx_in; j_ff <= j_in; brk_ff <= brk_in; c_ff <= c_in;
      mark_ff <= mark_in;
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         if (bank_ff) tab_a[wr_addr] <= wr_data;
         else tab_b[wr_addr] <= wr_data;
      end
      rd_ff <= bank_in ? tab_b[rd_addr] : tab_a[rd_addr];
   end

   always_comb begin
      logic [COORD_BITS-1:0] s, e, t;
      logic es, apply, merge;
      state_in = state_ff;
      ss_in = ss_ff; se_in = se_ff; rt_in = rt_ff; seen_in = seen_ff;
      lo_in = lo_ff; hi_in = hi_ff; bound_in = bound_ff; clip_in = clip_ff;
      any_in = any_ff; ovf_in = ovf_ff; bank_in = bank_ff;
      idx_in = idx_ff; cnt_in = cnt_ff; j_in = j_ff; brk_in = brk_ff; c_in = c_ff;
      mark_in = mark_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in = rsp_ff;
      wr_en = 1'b0; wr_addr = ri; wr_data = rd_ff;
      s = ss_ff; e = se_ff; t = rt_ff; es = seen_ff; apply = 1'b0; merge = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_data.func == FUNC_CLEAR) begin
                  cnt_in = '0; es = 1'b0; s = '0; e = '0; t = '0;
               end else if (req_data.no_elements) begin
                  es = 1'b0; s = '0; e = '0; t = '0; merge = 1'b1;
               end else begin
                  apply = es;
                  if (!es) begin
                     s = '0; e = '0; t = '0;
                     if (req_data.op_kind == OP_DELETION && req_data.trim) begin
                        s = req_data.run_length; e = req_data.run_length;
                     end else apply = 1'b1;
                  end
                  if (apply) begin
                     case (req_data.op_kind)
                        OP_MATCH:    e = sat_add(e, req_data.run_length);
                        OP_MISMATCH: e = sat_add(e, COORD_BITS'(1));
                        OP_DELETION: begin
                           if (req_data.trim) t = req_data.run_length;
                           else e = sat_add(e, req_data.run_length);
                        end
                        default: ;
                     endcase
                  end
                  es = 1'b1;
                  if (req_data.last) begin
                     es = 1'b0; merge = 1'b1;
                  end
               end
               ss_in = s; se_in = e; rt_in = t; seen_in = es;
               if (merge) begin
                  lo_in = s; hi_in = e; bound_in = sat_add(e, t);
                  any_in = 1'b0; idx_in = '0;
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (at_end) begin
               clip_in = (bound_ff > hi_ff) ? bound_ff - hi_ff : '0;
               ovf_in = !any_ff && cnt_ff >= CNT_BITS'(TABLE_DEPTH);
               idx_in = '0; j_in = '0;
               state_in = ST_PLACE;
            end else begin
               mark_in[ri] = !apart;
               if (!apart) begin
                  if (lo_ff >= rd_ff.lo) lo_in = rd_ff.lo;
                  if (hi_ff <= rd_ff.hi) hi_in = rd_ff.hi;
                  any_in = 1'b1;
               end
               idx_in = idx_ff + CNT_BITS'(1);
            end
         end
         ST_PLACE: begin
            if (at_end || (!mark_ff[ri] && rd_ff.lo > lo_ff)) begin
               brk_in = idx_ff; idx_in = '0; c_in = '0;
               state_in = ST_EMIT;
            end else begin
               if (!mark_ff[ri]) j_in = j_ff + CNT_BITS'(1);
               idx_in = idx_ff + CNT_BITS'(1);
            end
         end
         ST_EMIT: begin
            if (at_end) state_in = ST_FINAL;
            else if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in = '0;
               rsp_in.kind = KIND_REMAP;
               rsp_in.old_index = ri;
               if (mark_ff[ri]) begin
                  rsp_in.dest_index = j_ff[IDX_BITS-1:0];
                  rsp_in.absorbed = 1'b1;
               end else begin
                  rsp_in.dest_index = d[IDX_BITS-1:0];
                  c_in = c_ff + CNT_BITS'(1);
                  wr_en = !ovf_ff; wr_addr = d[IDX_BITS-1:0]; wr_data = rd_ff;
               end
               idx_in = idx_ff + CNT_BITS'(1);
            end
         end
         ST_FINAL: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in = '0;
               rsp_in.kind = KIND_NEW;
               rsp_in.dest_index = ovf_ff ? '0 : j_ff[IDX_BITS-1:0];
               rsp_in.block_start = lo_ff;
               rsp_in.block_end = hi_ff;
               rsp_in.clip_len = clip_ff;
               rsp_in.overflow = ovf_ff;
               rsp_in.done_res = 1'b1;
               if (!ovf_ff) begin
                  wr_en = 1'b1; wr_addr = j_ff[IDX_BITS-1:0];
                  wr_data = '{lo: lo_ff, hi: hi_ff, clip: clip_ff};
                  cnt_in = c_ff + CNT_BITS'(1);
                  bank_in = !bank_ff;
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   `IBM_ASSERT_NOW(a_cnt_range, clock, reset, 1'b1, cnt_ff <= CNT_BITS'(TABLE_DEPTH), "table count beyond depth")
   `IBM_ASSERT_NOW(a_idx_range, clock, reset, state_ff == ST_EMIT, idx_ff <= cnt_ff, "walk index past table")
   `IBM_ASSERT_NEXT(a_final_done, clock, reset, state_ff == ST_FINAL && out_free, state_ff == ST_IDLE && rsp_valid_ff && rsp_ff.done_res, "merge did not close with a done response")
endmodule
`default_nettype wire
